### hdl/tmss_pkg.sv
// ----------------------------------------------------------------------------
// Server selector package
// Shared widths, request, mode and status codes, and the request and result beat types.
// ----------------------------------------------------------------------------
`default_nettype none
package tmss_pkg;
	localparam int NumSlotsDef    = 16;
	localparam int NumBindingsDef = 128;
	localparam int MaskW          = 16;
	localparam int IdW            = 8;
	localparam int OpcW           = 14;
	localparam int SlsW           = 4;

	typedef enum logic [1:0] {
		REQ_SELECT = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_RESET  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_OVERRIDE  = 2'd0,
		MODE_LOADSHARE = 2'd1,
		MODE_ROUNDROBIN = 2'd2,
		MODE_BROADCAST = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NONE      = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam logic [1:0] CFG_MODE      = 2'd0;
	localparam logic [1:0] CFG_HASH_EN   = 2'd1;
	localparam logic [1:0] CFG_ORIG_SHFT = 2'd2;
	localparam logic [1:0] CFG_IDX_SHFT  = 2'd3;

	typedef struct packed {
		logic [1:0]     req_type;
		logic [IdW-1:0] server_id;
		logic [OpcW-1:0] origin_code;
		logic [SlsW-1:0] link_selector;
		logic [MaskW-1:0] active_mask;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]     status;
		logic [3:0]     chosen_slot;
		logic [IdW-1:0] chosen_id;
		logic           used_alternative;
		logic [4:0]     server_count;
	} rsp_beat_t;
endpackage
`default_nettype wire

### hdl/tmss_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// One beat carries a packed payload of width W.
// ----------------------------------------------------------------------------
`default_nettype none
interface tmss_if #(parameter int W = 8) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/tmss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module tmss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/traffic_mode_server_selector.sv
// ----------------------------------------------------------------------------
// Traffic mode server selector
// Keeps a table of server slots and a loadshare binding table, and answers
// add, delete, reset-bindings and select requests with one result beat each.
// ----------------------------------------------------------------------------
// Usage: requests arrive as beats on the req channel and every request gives
// exactly one beat on the rsp channel. Configuration is a plain write port
// (cfg_we, cfg_idx, cfg_data) and must only be written while idle.
// The binding table lives in a synchronous RAM with registered read data.
// The binding entry address is presented while the request is accepted, the
// entry is read back during the next cycle, and in the cycle after that the
// result is computed, the entry written back on a loadshare select and the
// result registered; rsp.valid then rises in S_OUT.
// One request is in flight at a time: a new request is accepted only after
// the result beat of the last one has been taken by the receiver.
// A delete of a present server sweeps all NUM_BINDINGS entries, reading each
// entry in S_SWEEP_RD and writing it back in S_SWEEP_WR, before its result
// beat is shown.
// A reset-bindings request clears a per-entry valid bit vector, so it takes
// the same time as a select.
// At reset all slots are empty, every binding is empty, the assign pointer
// sits on the last slot and the send pointer on slot zero; a clearing pass
// is not needed since binding validity is held in flip-flops.
// When the receiver stalls the result waits in the output register and the
// block takes no new request until it has been delivered.
// ----------------------------------------------------------------------------
`default_nettype none
module traffic_mode_server_selector #(
	parameter int NUM_SLOTS    = tmss_pkg::NumSlotsDef,
	parameter int NUM_BINDINGS = tmss_pkg::NumBindingsDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [1:0] cfg_data,
	tmss_if.sink            req,
	tmss_if.source          rsp
);
	import tmss_pkg::*;

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int BW = $clog2(NUM_BINDINGS);
	localparam int EW = 2 + 2 * SW;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_SWEEP_RD, S_SWEEP_WR, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] mode_q, oshift_q, ishift_q;
	logic       hash_en_q;
	req_beat_t  r_q;
	rsp_beat_t  o_q;
	logic [NUM_SLOTS-1:0] slot_valid_q;
	logic [IdW-1:0]       slot_id_q [NUM_SLOTS];
	logic [NUM_BINDINGS-1:0] bvalid_q;
	logic [SW-1:0] aptr_q, sptr_q;
	logic [BW-1:0] bidx_q, sweep_q;
	logic [SW-1:0] del_slot_q;

	// binding RAM
	logic          ram_we;
	logic [BW-1:0] ram_wa, ram_ra;
	logic [EW-1:0] ram_wd, ram_rd;

	tmss_ram #(.WIDTH(EW), .DEPTH(NUM_BINDINGS)) u_bind (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data  = o_q;

	req_beat_t rin;
	assign rin = req.data;

	// binding index hash
	logic [OpcW-1:0] v;
	logic [2:0]      f;
	logic [6:0]      ext;
	logic [6:0]      ext_sh;
	always_comb begin
		v = rin.origin_code >> oshift_q;
		f = v[11:9] ^ v[8:6] ^ v[5:3] ^ v[2:0];
		ext = hash_en_q ? {f, rin.link_selector}
		                : {3'd0, rin.link_selector};
		ext_sh = ext >> ishift_q;
	end

	// active slot vector: slots beyond the mask width count as inactive
	logic [NUM_SLOTS-1:0] act;
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			act[i] = slot_valid_q[i] && (i < MaskW) && r_q.active_mask[i % MaskW];
		end
	end

	// rotating search: first set bit after ptr, wrapping
	function automatic logic [SW:0] rr_find(input logic [NUM_SLOTS-1:0] vec,
			input logic [SW-1:0] ptr);
		logic [SW:0] res;
		logic [SW-1:0] k;
		res = '0;
		for (int j = NUM_SLOTS; j >= 1; j--) begin
			k = SW'((32'(ptr) + j) % NUM_SLOTS);
			if (vec[k]) res = {1'b1, k};
		end
		return res;
	endfunction

	function automatic logic [SW-1:0] nxt(input logic [SW-1:0] p);
		return SW'((32'(p) + 1) % NUM_SLOTS);
	endfunction

	// first set bit
	function automatic logic [SW:0] first_set(input logic [NUM_SLOTS-1:0] vec);
		logic [SW:0] res;
		res = '0;
		for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
			if (vec[j]) res = {1'b1, SW'(j)};
		end
		return res;
	endfunction

	// id match
	logic [NUM_SLOTS-1:0] idm;
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			idm[i] = slot_valid_q[i] && (slot_id_q[i] == r_q.server_id);
		end
	end

	// execute-stage logic
	logic          e_nv, e_av;
	logic [SW-1:0] e_ns, e_as;
	logic          x_found, x_alt, x_bwe;
	logic [SW-1:0] x_slot, x_aptr, x_sptr;
	logic [EW-1:0] x_bwd;
	logic [1:0]    x_status;
	logic [SW:0]   t, t2;
	logic          n_ok, a_ok;
	always_comb begin
		{e_nv, e_ns, e_av, e_as} = bvalid_q[bidx_q] ? ram_rd : '0;
		x_found = 1'b0; x_alt = 1'b0; x_slot = '0; x_bwe = 1'b0;
		x_aptr = aptr_q; x_sptr = sptr_q; x_status = ST_OK;
		x_bwd = {e_nv, e_ns, e_av, e_as};
		t = '0; t2 = '0;
		n_ok = e_nv && act[e_ns];
		a_ok = e_av && act[e_as];
		unique case (mode_t'(mode_q))
			MODE_OVERRIDE: begin
				t = first_set(act);
				x_found = t[SW]; x_slot = t[SW-1:0];
			end
			MODE_ROUNDROBIN: begin
				t = rr_find(act, sptr_q);
				x_found = t[SW]; x_slot = t[SW-1:0];
				x_sptr = t[SW] ? t[SW-1:0] : nxt(sptr_q);
			end
			MODE_BROADCAST: begin
				t = first_set(act);
				x_found = ($countones(act) == 1); x_slot = t[SW-1:0];
			end
			default: begin
				x_bwe = 1'b1;
				if (n_ok) begin
					x_found = 1'b1; x_slot = e_ns;
					x_bwd = {e_nv, e_ns, 1'b0, SW'(0)};
				end else if (a_ok) begin
					x_found = 1'b1; x_slot = e_as; x_alt = 1'b1;
				end else begin
					logic go;
					logic [SW-1:0] ns;
					go = 1'b1; ns = e_ns;
					if (!e_nv) begin
						t = rr_find(slot_valid_q, aptr_q);
						x_aptr = t[SW] ? t[SW-1:0] : nxt(aptr_q);
						if (!t[SW]) begin
							go = 1'b0;
						end else begin
							ns = t[SW-1:0];
							x_bwd = {1'b1, ns, e_av, e_as};
							if (act[ns]) begin
								go = 1'b0; x_found = 1'b1; x_slot = ns;
							end
						end
					end
					if (go) begin
						t2 = rr_find(act, sptr_q);
						x_sptr = t2[SW] ? t2[SW-1:0] : nxt(sptr_q);
						if (t2[SW]) begin
							x_found = 1'b1; x_alt = 1'b1; x_slot = t2[SW-1:0];
							x_bwd = {x_bwd[EW-1:SW+1], 1'b1, t2[SW-1:0]};
						end
					end
				end
			end
		endcase
		if (!x_found) begin
			x_status = ST_NONE; x_alt = 1'b0; x_slot = '0;
		end
	end

	// sweep entry update
	logic [EW-1:0] sw_wd;
	logic          s_nv, s_av;
	logic [SW-1:0] s_ns, s_as;
	always_comb begin
		{s_nv, s_ns, s_av, s_as} = bvalid_q[sweep_q] ? ram_rd : '0;
		if (s_nv && s_ns == del_slot_q) begin s_nv = 1'b0; s_ns = '0; end
		if (s_av && s_as == del_slot_q) begin s_av = 1'b0; s_as = '0; end
		sw_wd = {s_nv, s_ns, s_av, s_as};
	end

	// The read address follows the stage: the hashed index while idle, the
	// sweep position during a delete sweep, and the held index otherwise.
	always_comb begin
		if (state_q == S_IDLE) begin
			ram_ra = BW'(ext_sh);
		end else if (state_q == S_SWEEP_RD || state_q == S_SWEEP_WR) begin
			ram_ra = sweep_q;
		end else begin
			ram_ra = bidx_q;
		end
		ram_we = 1'b0; ram_wa = bidx_q; ram_wd = x_bwd;
		if (state_q == S_EXEC && r_q.req_type == REQ_SELECT && x_bwe) begin
			ram_we = 1'b1;
		end else if (state_q == S_SWEEP_WR) begin
			ram_we = 1'b1; ram_wa = sweep_q; ram_wd = sw_wd;
		end
	end

	logic [SW:0] hit, free;
	assign hit  = first_set(idm);
	assign free = first_set(~slot_valid_q);

	function automatic logic [4:0] cnt(input logic [NUM_SLOTS-1:0] vv);
		return 5'($countones(vv));
	endfunction

	// result beat built in the execute stage
	rsp_beat_t o_d;
	always_comb begin
		o_d = '0;
		o_d.server_count = cnt(slot_valid_q);
		case (req_t'(r_q.req_type))
			REQ_SELECT: begin
				o_d.status = x_status;
				o_d.chosen_slot = 4'(x_slot);
				o_d.chosen_id = x_found ? slot_id_q[x_slot] : '0;
				o_d.used_alternative = x_alt;
			end
			REQ_ADD: begin
				if (hit[SW]) begin
					o_d.chosen_slot = 4'(hit[SW-1:0]);
					o_d.chosen_id = r_q.server_id;
				end else if (free[SW]) begin
					o_d.chosen_slot = 4'(free[SW-1:0]);
					o_d.chosen_id = r_q.server_id;
					o_d.server_count = cnt(slot_valid_q) + 5'd1;
				end else begin
					o_d.status = ST_FULL;
				end
			end
			REQ_DELETE: begin
				if (hit[SW]) begin
					o_d.chosen_slot = 4'(hit[SW-1:0]);
					o_d.chosen_id = r_q.server_id;
					o_d.server_count = cnt(slot_valid_q) - 5'd1;
				end else begin
					o_d.status = ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= '0; hash_en_q <= 1'b0; oshift_q <= '0; ishift_q <= '0;
			slot_valid_q <= '0;
			bvalid_q <= '0;
			aptr_q <= SW'(NUM_SLOTS - 1);
			sptr_q <= '0;
			sweep_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MODE:      mode_q <= cfg_data;
					CFG_HASH_EN:   hash_en_q <= cfg_data[0];
					CFG_ORIG_SHFT: oshift_q <= cfg_data;
					CFG_IDX_SHFT:  ishift_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (req.valid) begin
					r_q <= req.data;
					bidx_q <= BW'(ext_sh);
					state_q <= S_READ;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					o_q <= o_d;
					state_q <= S_OUT;
					case (req_t'(r_q.req_type))
						REQ_SELECT: begin
							aptr_q <= x_aptr; sptr_q <= x_sptr;
							if (x_bwe) bvalid_q[bidx_q] <= 1'b1;
						end
						REQ_ADD: begin
							if (!hit[SW] && free[SW]) begin
								slot_valid_q[free[SW-1:0]] <= 1'b1;
								slot_id_q[free[SW-1:0]] <= r_q.server_id;
							end
						end
						REQ_DELETE: begin
							if (hit[SW]) begin
								slot_valid_q[hit[SW-1:0]] <= 1'b0;
								slot_id_q[hit[SW-1:0]] <= '0;
								del_slot_q <= hit[SW-1:0];
								sweep_q <= '0;
								state_q <= S_SWEEP_RD;
							end
						end
						default: begin
							bvalid_q <= '0;
							aptr_q <= SW'(NUM_SLOTS - 1);
						end
					endcase
				end
				S_SWEEP_RD: state_q <= S_SWEEP_WR;
				S_SWEEP_WR: begin
					if (sweep_q == BW'(NUM_BINDINGS - 1)) begin
						state_q <= S_OUT;
					end else begin
						sweep_q <= sweep_q + 1'b1;
						state_q <= S_SWEEP_RD;
					end
				end
				S_OUT: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/tmss_checker.sv
// ----------------------------------------------------------------------------
// Server selector port checker
// Watches the top level's ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
`default_nettype none
module tmss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [19:0] rsp_data
);
	import tmss_pkg::*;

	// One request in flight: no request is taken while a result is shown.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("request taken during result");

	// A result beat holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped");

	// Server count never exceeds sixteen.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data[4:0] <= 5'd16) else $error("bad count");

	// A result never appears directly after an accepted request.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid) else $error("early result");
endmodule

bind traffic_mode_server_selector tmss_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);
`default_nettype wire
